>>> hdl/lpr_pkg.sv
package lpr_pkg;

  localparam int BUF_DEPTH  = 4096;
  localparam int IDX_W      = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int SMP_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int PITCH_W    = 10;
  localparam int POS_SHIFT  = 24;
  localparam int NUM_W      = IDX_W + POS_SHIFT;
  localparam int POS_HI_W   = NUM_W - FRAC_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [PITCH_W-1:0] PITCH_MIN   = PITCH_W'(128);
  localparam logic [PITCH_W-1:0] PITCH_MAX   = PITCH_W'(512);
  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(307);
  localparam logic [FRAC_W-1:0]  FRAC_NEAR_ONE = FRAC_W'(65470);

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // register index taken from the word address bit
  localparam logic REG_PITCH = 1'b0;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_RD0  = 6'b000100,
    ST_RD1  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic go;
    logic done;
  } div_ctrl_t;

endpackage

>>> hdl/linear_interp_pitch_resampler_top.sv
// Linear-interpolation pitch resampler. A load request (in_command = 0) stores one
// sample while the buffer is open and not full, and busy stays low; the sample marked
// last closes the buffer. Each output request (in_command = 1) then returns output i,
// read from the buffer at position i*256/pitch (pitch clamped to 128..512) and
// interpolated between the two neighbouring samples: a bit-serial divider forms the
// position one quotient bit per clock, then two reads of the sample memory and one
// multiply follow. A request with no closed buffer answers in the next cycle with
// out_empty_res set. Results appear for exactly one cycle on out_strobe and the receiver
// cannot hold them off, so it must take every strobed result. Pitch is written over the
// APB port at address 0; the user must write it only while idle, which is not enforced.
module linear_interp_pitch_resampler_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic signed [15:0]           in_sample_in,
  input  logic                         in_last_in,
  output logic                         out_strobe,
  output logic signed [15:0]           out_sample_out,
  output logic                         out_last_out,
  output logic                         out_empty_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lpr_pkg::ADDR_W-1:0]   paddr,
  input  logic [lpr_pkg::DATA_W-1:0]   pwdata,
  output logic [lpr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import lpr_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [IDX_W-1:0]     idx_r;
  logic                 closed_r;
  logic [PITCH_W-1:0]   pitch_r;
  logic [PITCH_W-1:0]   pitch_eff;

  logic [SMP_W-1:0]     mem [BUF_DEPTH];
  logic [SMP_W-1:0]     rd_data_r;
  logic [IDX_W-1:0]     rd_addr;
  logic                 mem_we;

  logic [IDX_W-1:0]     i0_r, i1_r, i0_nxt, i1_nxt;
  logic [FRAC_W-1:0]    f_r, f_nxt;
  logic signed [SMP_W-1:0] a_r;
  logic signed [33:0]   prod_r;

  logic                 accept;
  logic                 have_buf;
  logic                 div_go;
  logic                 div_done;
  logic [NUM_W-1:0]     div_q;

  logic [POS_HI_W-1:0]  pos_hi;
  logic [CNT_W-1:0]     cnt_m1, cnt_m2;
  logic signed [16:0]   dsmp;
  logic signed [16:0]   fext;
  logic signed [34:0]   acc, acc_adj;
  logic                 fin;

  logic                 out_strobe_r;
  logic [SMP_W-1:0]     out_sample_r;
  logic                 out_last_r, out_empty_r;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign have_buf = closed_r && (count_r != '0);
  assign div_go   = accept && (in_command == CMD_REQUEST) && have_buf;

  lpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (idx_r),
    .divisor  (pitch_eff),
    .done     (div_done),
    .quot     (div_q)
  );

  always_comb begin
    if (pitch_r < PITCH_MIN)      pitch_eff = PITCH_MIN;
    else if (pitch_r > PITCH_MAX) pitch_eff = PITCH_MAX;
    else                          pitch_eff = pitch_r;
  end

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PITCH) ? DATA_W'(pitch_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r <= PITCH_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PITCH)) begin
      pitch_r <= pwdata[PITCH_W-1:0];
    end
  end

  // sample memory
  assign mem_we  = accept && (in_command == CMD_LOAD) && !closed_r &&
                   (count_r < CNT_W'(BUF_DEPTH));
  assign rd_addr = (state_r == ST_RD0) ? i0_r : i1_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= in_sample_in;
    end
    rd_data_r <= mem[rd_addr];
  end

  // source position clamp, neighbour indices and fraction
  always_comb begin
    pos_hi = div_q[NUM_W-1:FRAC_W];
    cnt_m1 = count_r - CNT_W'(1);
    cnt_m2 = count_r - CNT_W'(2);
    if (count_r == CNT_W'(1)) begin
      i0_nxt = '0;
      i1_nxt = '0;
      f_nxt  = '0;
    end else if (pos_hi >= POS_HI_W'(cnt_m1)) begin
      i0_nxt = cnt_m2[IDX_W-1:0];
      i1_nxt = cnt_m1[IDX_W-1:0];
      f_nxt  = FRAC_NEAR_ONE;
    end else begin
      i0_nxt = pos_hi[IDX_W-1:0];
      i1_nxt = pos_hi[IDX_W-1:0] + IDX_W'(1);
      f_nxt  = div_q[FRAC_W-1:0];
    end
  end

  // a*(1-f) + b*f as a + (b-a)*f, truncated toward zero
  always_comb begin
    dsmp    = $signed({rd_data_r[SMP_W-1], rd_data_r}) - $signed({a_r[SMP_W-1], a_r});
    fext    = $signed({1'b0, f_r});
    acc     = $signed({{3{a_r[SMP_W-1]}}, a_r, {FRAC_W{1'b0}}}) + 35'(prod_r);
    acc_adj = acc + (acc[34] ? 35'sd65535 : 35'sd0);
    fin     = ((CNT_W'(idx_r) + CNT_W'(1)) >= count_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIV && div_done) begin
      i0_r <= i0_nxt;
      i1_r <= i1_nxt;
      f_r  <= f_nxt;
    end
    if (state_r == ST_RD1) begin
      a_r <= rd_data_r;
    end
    if (state_r == ST_MUL) begin
      prod_r <= dsmp * fext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (div_go)   state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      closed_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (accept && in_command == CMD_LOAD && !closed_r) begin
        if (mem_we) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (in_last_in) begin
          closed_r <= 1'b1;
        end
      end
      if (accept && in_command == CMD_REQUEST && !have_buf) begin
        out_strobe_r <= 1'b1;
      end
      if (state_r == ST_FIN) begin
        out_strobe_r <= 1'b1;
        if (fin) begin
          count_r  <= '0;
          idx_r    <= '0;
          closed_r <= 1'b0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_REQUEST && !have_buf) begin
      out_sample_r <= '0;
      out_last_r   <= 1'b0;
      out_empty_r  <= 1'b1;
    end else if (state_r == ST_FIN) begin
      out_sample_r <= acc_adj[31:16];
      out_last_r   <= fin;
      out_empty_r  <= 1'b0;
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_sample_out = out_sample_r;
  assign out_last_out   = out_last_r;
  assign out_empty_res  = out_empty_r;

endmodule

>>> hdl/lpr_div.sv
module lpr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [lpr_pkg::IDX_W-1:0]   dividend,
  input  logic [lpr_pkg::PITCH_W-1:0] divisor,
  output logic                        done,
  output logic [lpr_pkg::NUM_W-1:0]   quot
);
  import lpr_pkg::*;

  localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic [NUM_W-1:0]   sh_r, sh_nxt;
  logic [PITCH_W-2:0] rem_r, rem_nxt;
  logic [PITCH_W-1:0] dvs_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               run_r;
  logic               done_r;
  logic [PITCH_W-1:0] trial;
  logic [PITCH_W-1:0] diff;
  logic               ge;

  // restoring division, dividend shifts out at the top, quotient in at the bottom
  always_comb begin
    trial   = {rem_r, sh_r[NUM_W-1]};
    ge      = (trial >= dvs_r);
    diff    = trial - dvs_r;
    rem_nxt = ge ? diff[PITCH_W-2:0] : trial[PITCH_W-2:0];
    sh_nxt  = {sh_r[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + STEP_W'(1);
        if (cnt_r == STEP_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh_r  <= {dividend, {POS_SHIFT{1'b0}}};
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = sh_r;

endmodule

>>> hdl/lpr_chk.sv
module lpr_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_command,
  input logic                       out_strobe,
  input logic signed [15:0]         out_sample_out,
  input logic                       out_last_out,
  input logic                       out_empty_res
);
  import lpr_pkg::*;

  // an empty answer carries a zero sample and never ends a buffer
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_empty_res |-> (out_sample_out == 16'sd0) && !out_last_out)
    else $error("empty result with data or last mark");

  // a load request never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_LOAD) |=> !out_strobe)
    else $error("result after a load request");

  // an output request either answers at once or starts work
  a_req_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == CMD_REQUEST) |=> out_strobe || busy)
    else $error("output request neither answered nor started");

  // an interpolated result only follows a busy period
  a_data_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_empty_res |-> $past(busy))
    else $error("data result without preceding work");

endmodule

bind linear_interp_pitch_resampler_top lpr_chk u_lpr_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_command     (in_command),
  .out_strobe     (out_strobe),
  .out_sample_out (out_sample_out),
  .out_last_out   (out_last_out),
  .out_empty_res  (out_empty_res)
);

>>> verif/pitch_resampler_checker.sv
module pitch_resampler_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              in_command,
  input  logic signed [lpr_pkg::SMP_W-1:0]  in_sample_in,
  input  logic                              in_last_in,
  input  logic                              out_strobe,
  input  logic signed [lpr_pkg::SMP_W-1:0]  out_sample_out,
  input  logic                              out_last_out,
  input  logic                              out_empty_res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [lpr_pkg::ADDR_W-1:0]        paddr,
  input  logic [lpr_pkg::DATA_W-1:0]        pwdata,
  output int                                pending,
  output int                                fails
);
  import lpr_pkg::*;

  localparam int FRAC_ONE    = 1 << FRAC_W;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    fin;
    logic                    empty;
  } out_word_t;

  logic signed [SMP_W-1:0] src_mem [BUF_DEPTH];
  int unsigned             src_count;
  int unsigned             next_out;
  logic                    buf_closed;
  logic [PITCH_W-1:0]      rate_q8;
  out_word_t               due_samples [$];

  initial begin
    pending = 0;
    fails   = 0;
  end

  task automatic report_fault(input string msg);
    if (fails < PRINT_LIMIT) $display("checker: %s at %0t", msg, $time);
    fails++;
  endtask

  // source read at idx*256/pitch, linear blend of the two neighbours
  function automatic logic signed [SMP_W-1:0] interp_sample(input int unsigned idx,
                                                            input int unsigned n);
    longint unsigned rate;
    longint unsigned pos;
    longint unsigned lim;
    int unsigned     i0;
    int unsigned     i1;
    int unsigned     f;
    longint          a;
    longint          b;
    longint          acc;
    if (n <= 1) return src_mem[0];
    rate = rate_q8;
    if (rate < PITCH_MIN) rate = PITCH_MIN;
    if (rate > PITCH_MAX) rate = PITCH_MAX;
    pos = (64'(idx) << POS_SHIFT) / rate;
    lim = 64'(n - 1) << FRAC_W;
    // past the end the position sticks just short of the last sample
    if (pos >= lim) pos = (64'(n - 2) << FRAC_W) + FRAC_NEAR_ONE;
    i0 = int'(pos >> FRAC_W);
    f  = int'(pos & 64'(FRAC_ONE - 1));
    i1 = i0 + 1;
    if (i0 > n - 1) i0 = n - 1;
    if (i1 > n - 1) i1 = n - 1;
    a = src_mem[i0];
    b = src_mem[i1];
    acc = a * longint'(FRAC_ONE - f) + b * longint'(f);
    // signed division, truncates toward zero
    return SMP_W'(acc / FRAC_ONE);
  endfunction

  always @(posedge clk) begin : monitor
    out_word_t want;
    out_word_t nxt;
    if (!rst_n) begin
      src_count  = 0;
      next_out   = 0;
      buf_closed = 1'b0;
      rate_q8    = PITCH_RESET;
      due_samples.delete();
    end else begin
      if (out_strobe) begin
        if (due_samples.size() == 0) begin
          report_fault($sformatf("result with no request outstanding: sample %0d last %0b empty %0b",
                                 out_sample_out, out_last_out, out_empty_res));
        end else begin
          want = due_samples.pop_front();
          if (out_sample_out !== want.smp)
            report_fault($sformatf("sample_out expected %0d got %0d", want.smp, out_sample_out));
          if (out_last_out !== want.fin)
            report_fault($sformatf("last_out expected %0b got %0b", want.fin, out_last_out));
          if (out_empty_res !== want.empty)
            report_fault($sformatf("empty_res expected %0b got %0b", want.empty, out_empty_res));
        end
      end

      if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_PITCH)
        rate_q8 = pwdata[PITCH_W-1:0];

      if (start && !busy) begin
        if (in_command == CMD_LOAD) begin
          // loads are ignored once the buffer is closed
          if (!buf_closed) begin
            if (src_count < BUF_DEPTH) begin
              src_mem[src_count] = in_sample_in;
              src_count++;
            end
            if (in_last_in) buf_closed = 1'b1;
          end
        end else if (!buf_closed || src_count == 0) begin
          nxt.smp   = '0;
          nxt.fin   = 1'b0;
          nxt.empty = 1'b1;
          due_samples.push_back(nxt);
        end else begin
          nxt.smp   = interp_sample(next_out, src_count);
          nxt.fin   = (next_out + 1 >= src_count);
          nxt.empty = 1'b0;
          due_samples.push_back(nxt);
          if (nxt.fin) begin
            src_count  = 0;
            next_out   = 0;
            buf_closed = 1'b0;
          end else begin
            next_out++;
          end
        end
      end
    end
    pending = due_samples.size();
  end

endmodule

>>> verif/linear_interp_pitch_resampler_top_tb.sv
module linear_interp_pitch_resampler_top_tb;
  import lpr_pkg::*;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int NUM_PHASES    = 10;
  localparam int SETTLE_CYCLES = 60;
  localparam int QUIET_LIMIT   = 1000;

  localparam logic [ADDR_W-1:0] PITCH_ADDR = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

  logic                    clk;
  logic                    rst_n        = 1'b0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic                    in_command   = CMD_LOAD;
  logic signed [SMP_W-1:0] in_sample_in = '0;
  logic                    in_last_in   = 1'b0;
  logic                    out_strobe;
  logic signed [SMP_W-1:0] out_sample_out;
  logic                    out_last_out;
  logic                    out_empty_res;
  logic                    psel         = 1'b0;
  logic                    penable      = 1'b0;
  logic                    pwrite       = 1'b0;
  logic [ADDR_W-1:0]       paddr        = '0;
  logic [DATA_W-1:0]       pwdata       = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;

  int pending;
  int fails;
  int quiet_cycles = 0;
  int counted      = 0;
  bit no_gaps      = 1'b0;

  int pitch_plan [8] = '{0, 1023, 128, 512, 127, 513, 256, 300};

  linear_interp_pitch_resampler_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_sample_in  (in_sample_in),
    .in_last_in    (in_last_in),
    .out_strobe    (out_strobe),
    .out_sample_out(out_sample_out),
    .out_last_out  (out_last_out),
    .out_empty_res (out_empty_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  pitch_resampler_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_sample_in  (in_sample_in),
    .in_last_in    (in_last_in),
    .out_strobe    (out_strobe),
    .out_sample_out(out_sample_out),
    .out_last_out  (out_last_out),
    .out_empty_res (out_empty_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pending       (pending),
    .fails         (fails)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SMP_W'($urandom_range(0, 64) - 32);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // one request, held until busy is low at a rising edge
  task automatic send(input logic cmd, input logic signed [SMP_W-1:0] smp, input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_command   <= cmd;
    in_sample_in <= smp;
    in_last_in   <= last;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // loads leave no result, so give the block its full latency before touching config
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // well-formed buffer with a little noise: early requests and loads while closed
  task automatic run_buffer(input int n);
    int k;
    no_gaps = ($urandom_range(0, 3) == 0);
    for (k = 0; k < n; k++) begin
      if (k > 0 && $urandom_range(0, 14) == 0) begin
        send(CMD_REQUEST, rand_sample(), 1'($urandom));
        counted++;
      end
      send(CMD_LOAD, rand_sample(), k == n - 1);
      counted++;
    end
    if ($urandom_range(0, 5) == 0) send(CMD_LOAD, rand_sample(), 1'($urandom));
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 24) == 0) hold_until_drained();
      send(CMD_REQUEST, rand_sample(), 1'($urandom));
      counted++;
    end
    if ($urandom_range(0, 7) == 0) begin
      send(CMD_REQUEST, rand_sample(), 1'($urandom));
      counted++;
    end
  endtask

  initial begin : stimulus
    int ph;
    int k;
    int quota;
    logic [PITCH_W-1:0] rate;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part at the reset pitch
    send(CMD_REQUEST, 16'sh0000, 1'b0);
    send(CMD_LOAD,    16'sh7FFF, 1'b0);
    send(CMD_REQUEST, 16'sh7FFF, 1'b1);
    send(CMD_LOAD,    16'sh8000, 1'b0);
    send(CMD_LOAD,    16'sh0000, 1'b0);
    send(CMD_LOAD,    -16'sd1,   1'b0);
    send(CMD_LOAD,    16'sd12345, 1'b1);
    send(CMD_LOAD,    16'sd777,  1'b1);
    for (k = 0; k < 5; k++) send(CMD_REQUEST, 16'sh8000, 1'b0);
    // single sample buffer
    send(CMD_LOAD,    16'sh8000, 1'b1);
    send(CMD_REQUEST, 16'sh0000, 1'b0);
    send(CMD_REQUEST, 16'sh0000, 1'b0);
    // two samples, full swing
    send(CMD_LOAD,    16'sh7FFF, 1'b0);
    send(CMD_LOAD,    16'sh8000, 1'b1);
    send(CMD_REQUEST, 16'sh7FFF, 1'b1);
    send(CMD_REQUEST, -16'sd1,   1'b1);

    // writes to the unused register slot must not move the pitch
    settle();
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);

    quota = RANDOM_ITEMS / NUM_PHASES;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      rate = (ph < 8) ? PITCH_W'(pitch_plan[ph]) : PITCH_W'($urandom_range(0, 1023));
      cfg_write(PITCH_ADDR, {$urandom} & ~32'(10'h3FF) | 32'(rate));
      while (counted < quota * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) run_buffer($urandom_range(25, 300));
        else run_buffer($urandom_range(1, 24));
      end
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/lpr_pkg.sv
hdl/lpr_div.sv
hdl/linear_interp_pitch_resampler_top.sv
hdl/lpr_chk.sv
verif/pitch_resampler_checker.sv
verif/linear_interp_pitch_resampler_top_tb.sv
